### rtl/srsw_pkg.sv
package srsw_pkg;

	localparam int MODE_W    = 2;
	localparam int KIND_W    = 2;
	localparam int SEQ_PORT_W = 4;
	localparam int CNT_PORT_W = 4;
	localparam int AGE_W     = 16;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [MODE_W-1:0] MODE_SEND = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ACK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TICK = 2'd2;

	localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RETX    = 2'd3;

	localparam logic             REG_TIMEOUT   = 1'b0;
	localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd2;

	typedef struct packed {
		logic start;
		logic send;
		logic ack;
		logic slide;
		logic scan_rd;
		logic scan_ev;
		logic push;
		logic push_last;
	} cmd_t;

	typedef struct packed {
		logic fl_zero;
		logic ack_slide;
		logic can_slide;
		logic scan_last;
		logic expired;
		logic pend_retx;
		logic out_free;
	} sts_t;

endpackage

### rtl/srsw_ram.sv
module srsw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/srsw_ctrl.sv
module srsw_ctrl import srsw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [MODE_W-1:0] mode,
	input  sts_t              st,
	output cmd_t              cmd
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SEND  = 7'b0000010,
		ST_ACK   = 7'b0000100,
		ST_SLIDE = 7'b0001000,
		ST_RD    = 7'b0010000,
		ST_EV    = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.start = 1'b1;
					unique case (mode)
						MODE_SEND: state_d = ST_SEND;
						MODE_ACK:  state_d = ST_ACK;
						MODE_TICK: state_d = st.fl_zero ? ST_EMIT : ST_RD;
						default:   state_d = ST_EMIT;
					endcase
				end
			end
			ST_SEND: begin
				cmd.send = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_ACK: begin
				cmd.ack = 1'b1;
				state_d = st.ack_slide ? ST_SLIDE : ST_EMIT;
			end
			ST_SLIDE: begin
				if (st.can_slide) begin
					cmd.slide = 1'b1;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = ST_EV;
			end
			ST_EV: begin
				if (!(st.expired && st.pend_retx && !st.out_free)) begin
					cmd.scan_ev = 1'b1;
					cmd.push    = st.expired && st.pend_retx;
					state_d     = st.scan_last ? ST_EMIT : ST_RD;
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/srsw_dp.sv
module srsw_dp import srsw_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  st,
	input  logic [SEQ_PORT_W-1:0] ack_seq,
	input  logic                  ack_intact,
	input  logic [AGE_W-1:0]      timeout,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [SEQ_PORT_W-1:0] seq,
	output logic [SEQ_PORT_W-1:0] window_base,
	output logic [CNT_PORT_W-1:0] outstanding,
	output logic                  last
);

	localparam int SEQ_MOD = 2 * WINDOW;
	localparam int SEQ_W   = $clog2(SEQ_MOD);
	localparam int SLOT_W  = $clog2(WINDOW);
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int ACK_W   = (SEQ_W + 1 > SEQ_PORT_W) ? SEQ_W + 1 : SEQ_PORT_W;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [SEQ_W-1:0] s);
		to_slot = (s >= SEQ_W'(WINDOW)) ? SLOT_W'(s - SEQ_W'(WINDOW)) : SLOT_W'(s);
	endfunction

	function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
		seq_inc = (s == SEQ_W'(SEQ_MOD - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [SEQ_W-1:0] seq_diff(input logic [SEQ_W-1:0] a,
		input logic [SEQ_W-1:0] b);
		logic [SEQ_W:0] wrap;
		wrap = (SEQ_W + 1)'(a) + (SEQ_W + 1)'(SEQ_MOD) - (SEQ_W + 1)'(b);
		seq_diff = (a >= b) ? a - b : SEQ_W'(wrap);
	endfunction

	logic [SEQ_W-1:0]      base_q;
	logic [SEQ_W-1:0]      next_q;
	logic [WINDOW-1:0]     busy_q;
	logic [WINDOW-1:0]     acked_q;
	logic [CNT_W-1:0]      outs_q;
	logic [SLOT_W-1:0]     off_q;
	logic [SEQ_PORT_W-1:0] ack_q;
	logic                  intact_q;
	logic [KIND_W-1:0]     pend_kind_q;
	logic [SEQ_W-1:0]      pend_seq_q;
	logic                  pend_retx_q;
	logic                  out_valid_q;
	logic [KIND_W-1:0]     kind_q;
	logic [SEQ_PORT_W-1:0] seq_q;
	logic [SEQ_PORT_W-1:0] base_out_q;
	logic [CNT_PORT_W-1:0] outs_out_q;
	logic                  last_q;

	logic [CNT_W-1:0]  fl;
	logic              full;
	logic [SLOT_W-1:0] next_slot;
	logic [SLOT_W-1:0] base_slot;
	logic [SEQ_W-1:0]  ack_s;
	logic [SLOT_W-1:0] ack_slot;
	logic              ack_hit;
	logic [SEQ_W:0]    scan_sum;
	logic [SEQ_W-1:0]  scan_seq;
	logic [SLOT_W-1:0] scan_slot;
	logic              scan_skip;
	logic [AGE_W-1:0]  age;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [AGE_W-1:0]  ram_wdata;
	logic              alloc;

	assign fl        = CNT_W'(seq_diff(next_q, base_q));
	assign full      = fl >= CNT_W'(WINDOW);
	assign next_slot = to_slot(next_q);
	assign base_slot = to_slot(base_q);
	assign ack_s     = SEQ_W'(ack_q);
	assign ack_slot  = to_slot(ack_s);
	assign ack_hit   = intact_q && (ACK_W'(ack_q) < ACK_W'(SEQ_MOD))
		&& (seq_diff(ack_s, base_q) < SEQ_W'(fl));
	assign scan_sum  = (SEQ_W + 1)'(base_q) + (SEQ_W + 1)'(off_q);
	assign scan_seq  = (scan_sum >= (SEQ_W + 1)'(SEQ_MOD))
		? SEQ_W'(scan_sum - (SEQ_W + 1)'(SEQ_MOD)) : SEQ_W'(scan_sum);
	assign scan_slot = to_slot(scan_seq);
	assign scan_skip = !busy_q[scan_slot] || acked_q[scan_slot];
	assign alloc     = cmd.send && !full;

	assign st.fl_zero   = (fl == '0);
	assign st.ack_slide = ack_hit && (ack_s == base_q);
	assign st.can_slide = (fl != '0) && acked_q[base_slot];
	assign st.scan_last = (CNT_W'(off_q) + 1'b1) == fl;
	assign st.expired   = !scan_skip && (age >= timeout);
	assign st.pend_retx = pend_retx_q;
	assign st.out_free  = !out_valid_q || result_ready;

	assign ram_we    = alloc || (cmd.scan_ev && !scan_skip);
	assign ram_waddr = cmd.send ? next_slot : scan_slot;
	assign ram_wdata = (cmd.send || st.expired) ? '0 : AGE_W'(age + 1'b1);

	srsw_ram #(
		.WIDTH(AGE_W),
		.DEPTH(WINDOW)
	) u_age (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.scan_rd),
		.raddr(scan_slot),
		.rdata(age)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			next_q      <= '0;
			busy_q      <= '0;
			acked_q     <= '0;
			outs_q      <= '0;
			pend_retx_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				pend_retx_q <= 1'b0;
			end
			if (alloc) begin
				busy_q[next_slot]  <= 1'b1;
				acked_q[next_slot] <= 1'b0;
				next_q             <= seq_inc(next_q);
				outs_q             <= outs_q + 1'b1;
			end
			if (cmd.ack && ack_hit) begin
				acked_q[ack_slot] <= 1'b1;
				if (!acked_q[ack_slot]) begin
					outs_q <= outs_q - 1'b1;
				end
			end
			if (cmd.slide) begin
				busy_q[base_slot]  <= 1'b0;
				acked_q[base_slot] <= 1'b0;
				base_q             <= seq_inc(base_q);
			end
			if (cmd.scan_ev && st.expired) begin
				pend_retx_q <= 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ack_q       <= ack_seq;
			intact_q    <= ack_intact;
			off_q       <= '0;
			pend_kind_q <= KIND_STATUS;
			pend_seq_q  <= '0;
		end
		if (cmd.send) begin
			pend_kind_q <= full ? KIND_REFUSED : KIND_SENT;
			pend_seq_q  <= full ? '0 : next_q;
		end
		if (cmd.scan_ev) begin
			off_q <= off_q + 1'b1;
			if (st.expired) begin
				pend_kind_q <= KIND_RETX;
				pend_seq_q  <= scan_seq;
			end
		end
		if (cmd.push) begin
			kind_q     <= pend_kind_q;
			seq_q      <= SEQ_PORT_W'(pend_seq_q);
			base_out_q <= SEQ_PORT_W'(base_q);
			outs_out_q <= CNT_PORT_W'(outs_q);
			last_q     <= cmd.push_last;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign seq          = seq_q;
	assign window_base  = base_out_q;
	assign outstanding  = outs_out_q;
	assign last         = last_q;

endmodule

### rtl/selective_repeat_send_window.sv
// A send or acknowledge passes through its own state and then the emit state, which registers the result.
// An acknowledgement of the window base adds a slide state that moves the base past each acknowledged base slot.
// A tick visits every in-flight slot with one age memory read and one update, then emits.
// One transaction is in work at a time; the result register lets the next one be accepted.
// Reset is asynchronous and clears the window, the control state and the timeout to 2;
// the age memory is not cleared, since every send writes its slot's age.
module selective_repeat_send_window import srsw_pkg::*; #(
	parameter int WINDOW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  logic [MODE_W-1:0]     mode,
	input  logic [SEQ_PORT_W-1:0] ack_seq,
	input  logic                  ack_intact,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic [KIND_W-1:0]     kind,
	output logic [SEQ_PORT_W-1:0] seq,
	output logic [SEQ_PORT_W-1:0] window_base,
	output logic [CNT_PORT_W-1:0] outstanding,
	output logic                  last
);

	logic [AGE_W-1:0] timeout_q;
	cmd_t             cmd;
	sts_t             st;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? CFG_DATA_W'(timeout_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
			timeout_q <= pwdata[AGE_W-1:0];
		end
	end

	srsw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.mode      (mode),
		.st        (st),
		.cmd       (cmd)
	);

	srsw_dp #(
		.WINDOW(WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.ack_seq     (ack_seq),
		.ack_intact  (ack_intact),
		.timeout     (timeout_q),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind        (kind),
		.seq         (seq),
		.window_base (window_base),
		.outstanding (outstanding),
		.last        (last)
	);

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> st.out_free)
		else $error("Result pushed while the output register is occupied.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("A transaction was accepted while another is still in work.");

	a_slide_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.slide |-> st.can_slide && !st.fl_zero)
		else $error("Window base slid over an unacknowledged or empty slot.");

endmodule
